// ----- sv/hpst_pkg.sv -----
// Package with the command and result types and the codes of the handle slot table.
`timescale 1ns / 1ps

package hpst_pkg;

    // Fixed field widths of the command and result transfers.
    localparam int ACTION_W   = 3;
    localparam int HANDLE_W   = 6;
    localparam int PAYLOAD_W  = 32;
    localparam int ENERGY_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // Number of distinct handles the handle field can name.
    localparam int HANDLE_SPAN = 64;

    // Capacity register reset value.
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE_EN = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_POS = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]         action;
        logic [HANDLE_W-1:0]         handle;
        logic [HANDLE_W-1:0]         dense_index;
        logic [PAYLOAD_W-1:0]        payload;
        logic signed [ENERGY_W-1:0]  energy;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [HANDLE_W-1:0]         handle_out;
        logic [HANDLE_W-1:0]         dense_out;
        logic [PAYLOAD_W-1:0]        payload_out;
        logic signed [ENERGY_W-1:0]  energy_out;
        logic [COUNT_W-1:0]          live_count;
    } t_result;

endpackage

// ----- sv/hpst_ram.sv -----
// Generic single-port synchronous RAM with a registered, read-first output.
`timescale 1ns / 1ps

module hpst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/handle_packed_slot_table.sv -----
// Top level of the stable-handle table over a packed dense store.
// A refused command, an unused action or a fresh-handle create has its result registered on
// the accepting edge; a create with a recycled handle first passes S_CR_POP, a read by
// position S_RD_POS, a read or energy write by handle S_H_MAP and S_H_DATA, and a remove
// S_RM_MAP, S_RM_HOLE, S_RM_LAST and S_RM_PUSH, as each memory has a single port. A new
// command may start in the cycle its predecessor's result is shown. The receiver cannot
// stall. Reset is synchronous and clears all live flags at once: no clearing pass.
`timescale 1ns / 1ps

module handle_packed_slot_table #(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  hpst_pkg::t_cmd             i_cmd,
    output logic                       o_done,
    output hpst_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hpst_pkg::COUNT_W-1:0] i_cfg_data
);

    import hpst_pkg::*;

    // Only HANDLE_SPAN handles can ever be named, and a create needs live + 1 below the
    // capacity, so no more than this many entries or handles exist at once.
    localparam int MAP_DEPTH = (SLOTS < HANDLE_SPAN) ? SLOTS : HANDLE_SPAN;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int PB        = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
    localparam logic [AW-1:0] TOP_IDX = AW'(MAP_DEPTH - 1);

    // One word of the dense store. The owner field is the handle that lives at that
    // dense position.
    typedef struct packed {
        logic [AW-1:0]               owner;
        logic [PB-1:0]               payload;
        logic signed [ENERGY_W-1:0]  energy;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CR_POP,
        S_RD_POS,
        S_H_MAP,
        S_H_DATA,
        S_RM_MAP,
        S_RM_HOLE,
        S_RM_LAST,
        S_RM_PUSH
    } t_state;

    // Control and bookkeeping registers.
    t_state                r_state;
    logic                  r_done;
    t_result               r_result;
    logic [COUNT_W-1:0]    r_capacity;
    logic [AW-1:0]         r_live;
    logic [AW-1:0]         r_free;
    logic [AW-1:0]         r_fresh;
    logic                  r_alive [MAP_DEPTH];

    // Per-command working registers.
    t_cmd                  r_cmd;
    logic [AW-1:0]         r_pos;
    t_slot                 r_old;

    // Memory ports. Memory A maps a handle to its dense position. Memory B is the dense
    // store; its upper, unused end also holds the free-handle stack, growing downward from
    // the top entry. Live entries plus freed handles never exceed MAP_DEPTH - 1, so the
    // stack never reaches a live dense position.
    logic                  a_we;
    logic [AW-1:0]         a_addr;
    logic [AW-1:0]         a_wdata;
    logic [AW-1:0]         a_rdata;
    logic                  b_we;
    logic [AW-1:0]         b_addr;
    t_slot                 b_wdata;
    t_slot                 b_rdata;

    logic                  accept;
    logic                  h_in_range;
    logic [AW-1:0]         h_idx;
    logic                  h_live;
    logic [COUNT_W-1:0]    cap_lim;
    logic                  create_ok;
    logic                  pos_ok;
    logic [AW-1:0]         pop_idx;
    logic [AW-1:0]         push_idx;
    logic [AW-1:0]         last_idx;
    logic [AW-1:0]         n_live_up;
    logic [AW-1:0]         n_live_down;

    hpst_ram #(
        .WIDTH (AW),
        .DEPTH (MAP_DEPTH),
        .ADDR_W(AW)
    ) u_handle_map (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_addr (a_addr),
        .i_wdata(a_wdata),
        .o_rdata(a_rdata)
    );

    hpst_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (MAP_DEPTH),
        .ADDR_W(AW)
    ) u_dense_store (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_addr (b_addr),
        .i_wdata(b_wdata),
        .o_rdata(b_rdata)
    );

    // Builds one result transfer; the payload is zero-extended to the port width.
    function automatic t_result make_result(
        input logic [STATUS_W-1:0]        status,
        input logic [AW-1:0]              handle,
        input logic [AW-1:0]              dense,
        input logic [PB-1:0]              payload,
        input logic signed [ENERGY_W-1:0] energy,
        input logic [AW-1:0]              live
    );
        t_result res;
        res.status      = status;
        res.handle_out  = HANDLE_W'(handle);
        res.dense_out   = HANDLE_W'(dense);
        res.payload_out = PAYLOAD_W'(payload);
        res.energy_out  = energy;
        res.live_count  = COUNT_W'(live);
        return res;
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Handle checks happen on the accepting edge against the live flags, which sit in
    // flip-flops so that a dead handle is refused without a memory access.
    assign h_in_range = (COUNT_W'(i_cmd.handle) < COUNT_W'(MAP_DEPTH));
    assign h_idx      = AW'(i_cmd.handle);
    assign h_live     = h_in_range && r_alive[h_idx];

    // Capacity values above the table size act as the table size.
    assign cap_lim   = (r_capacity > COUNT_W'(MAP_DEPTH)) ? COUNT_W'(MAP_DEPTH) : r_capacity;
    assign create_ok = ((COUNT_W'(r_live) + COUNT_W'(1)) < cap_lim);
    assign pos_ok    = (COUNT_W'(i_cmd.dense_index) < COUNT_W'(r_live));

    assign pop_idx     = TOP_IDX - (r_free - AW'(1));
    assign push_idx    = TOP_IDX - r_free;
    assign last_idx    = r_live - AW'(1);
    assign n_live_up   = r_live + AW'(1);
    assign n_live_down = r_live - AW'(1);

    // Memory addressing for each step of a command.
    always_comb begin
        a_we    = 1'b0;
        a_addr  = '0;
        a_wdata = '0;
        b_we    = 1'b0;
        b_addr  = '0;
        b_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        ACT_CREATE: begin
                            if (create_ok && (r_free == '0)) begin
                                a_we            = 1'b1;
                                a_addr          = r_fresh;
                                a_wdata         = r_live;
                                b_we            = 1'b1;
                                b_addr          = r_live;
                                b_wdata.owner   = r_fresh;
                                b_wdata.payload = i_cmd.payload[PB-1:0];
                                b_wdata.energy  = i_cmd.energy;
                            end else begin
                                b_addr = pop_idx;
                            end
                        end
                        ACT_REMOVE, ACT_READ, ACT_WRITE_EN: begin
                            a_addr = h_idx;
                        end
                        ACT_READ_POS: begin
                            b_addr = AW'(i_cmd.dense_index);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CR_POP: begin
                a_we            = 1'b1;
                a_addr          = b_rdata.owner;
                a_wdata         = r_live;
                b_we            = 1'b1;
                b_addr          = r_live;
                b_wdata.owner   = b_rdata.owner;
                b_wdata.payload = r_cmd.payload[PB-1:0];
                b_wdata.energy  = r_cmd.energy;
            end
            S_H_MAP: begin
                b_addr = a_rdata;
            end
            S_H_DATA: begin
                if (r_cmd.action == ACT_WRITE_EN) begin
                    b_we           = 1'b1;
                    b_addr         = r_pos;
                    b_wdata        = b_rdata;
                    b_wdata.energy = r_cmd.energy;
                end
            end
            S_RM_MAP: begin
                b_addr = a_rdata;
            end
            S_RM_HOLE: begin
                b_addr = last_idx;
            end
            S_RM_LAST: begin
                // The last entry moves into the hole, and its handle is repointed.
                if (last_idx != r_pos) begin
                    b_we    = 1'b1;
                    b_addr  = r_pos;
                    b_wdata = b_rdata;
                    a_we    = 1'b1;
                    a_addr  = b_rdata.owner;
                    a_wdata = r_pos;
                end
            end
            S_RM_PUSH: begin
                b_we          = 1'b1;
                b_addr        = push_idx;
                b_wdata.owner = AW'(r_cmd.handle);
            end
            default: begin
            end
        endcase
    end

    // Sequencer, bookkeeping and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_result   <= '0;
            r_capacity <= CAPACITY_RESET;
            r_live     <= '0;
            r_free     <= '0;
            r_fresh    <= '0;
            r_cmd      <= '0;
            r_pos      <= '0;
            r_old      <= '0;
            for (int i = 0; i < MAP_DEPTH; i++) begin
                r_alive[i] <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.action)
                            ACT_CREATE: begin
                                if (!create_ok) begin
                                    r_done   <= 1'b1;
                                    r_result <= make_result(ST_FULL, '0, '0, '0, '0, r_live);
                                end else if (r_free == '0) begin
                                    r_alive[r_fresh] <= 1'b1;
                                    r_fresh          <= r_fresh + AW'(1);
                                    r_live           <= n_live_up;
                                    r_done           <= 1'b1;
                                    r_result         <= make_result(ST_OK, r_fresh, r_live,
                                        i_cmd.payload[PB-1:0], i_cmd.energy, n_live_up);
                                end else begin
                                    r_free  <= r_free - AW'(1);
                                    r_state <= S_CR_POP;
                                end
                            end
                            ACT_REMOVE: begin
                                if (h_live && (r_live != '0)) begin
                                    r_state <= S_RM_MAP;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_result <= make_result(ST_DEAD, '0, '0, '0, '0, r_live);
                                end
                            end
                            ACT_READ, ACT_WRITE_EN: begin
                                if (h_live) begin
                                    r_state <= S_H_MAP;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_result <= make_result(ST_DEAD, '0, '0, '0, '0, r_live);
                                end
                            end
                            ACT_READ_POS: begin
                                if (pos_ok) begin
                                    r_state <= S_RD_POS;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_result <= make_result(ST_DEAD, '0, '0, '0, '0, r_live);
                                end
                            end
                            default: begin
                                r_done   <= 1'b1;
                                r_result <= make_result(ST_OK, '0, '0, '0, '0, r_live);
                            end
                        endcase
                    end
                end
                S_CR_POP: begin
                    r_alive[b_rdata.owner] <= 1'b1;
                    r_live                 <= n_live_up;
                    r_done                 <= 1'b1;
                    r_result               <= make_result(ST_OK, b_rdata.owner, r_live,
                        r_cmd.payload[PB-1:0], r_cmd.energy, n_live_up);
                    r_state                <= S_IDLE;
                end
                S_RD_POS: begin
                    r_done   <= 1'b1;
                    r_result <= make_result(ST_OK, b_rdata.owner, AW'(r_cmd.dense_index),
                        b_rdata.payload, b_rdata.energy, r_live);
                    r_state  <= S_IDLE;
                end
                S_H_MAP: begin
                    r_pos   <= a_rdata;
                    r_state <= S_H_DATA;
                end
                S_H_DATA: begin
                    r_done   <= 1'b1;
                    r_result <= make_result(ST_OK, AW'(r_cmd.handle), r_pos, b_rdata.payload,
                        (r_cmd.action == ACT_WRITE_EN) ? r_cmd.energy : b_rdata.energy,
                        r_live);
                    r_state  <= S_IDLE;
                end
                S_RM_MAP: begin
                    r_pos   <= a_rdata;
                    r_state <= S_RM_HOLE;
                end
                S_RM_HOLE: begin
                    r_old   <= b_rdata;
                    r_state <= S_RM_LAST;
                end
                S_RM_LAST: begin
                    r_state <= S_RM_PUSH;
                end
                S_RM_PUSH: begin
                    r_alive[AW'(r_cmd.handle)] <= 1'b0;
                    r_free                     <= r_free + AW'(1);
                    r_live                     <= n_live_down;
                    r_done                     <= 1'b1;
                    r_result                   <= make_result(ST_OK, AW'(r_cmd.handle), r_pos,
                        r_old.payload, r_old.energy, n_live_down);
                    r_state                    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/hpst_checker.sv -----
// Port-level checker for the handle slot table and its bind to the top level.
`timescale 1ns / 1ps

module hpst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input hpst_pkg::t_result o_result
);

    import hpst_pkg::*;

    // A result transfer always ends the command, so the block is free while it is shown.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while the block is still busy");

    // An accepted command either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted command vanished without a result");

    // The block only goes idle by delivering a result.
    a_fall_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result transfer");

    // A refused command changes nothing, so the live count repeats the previous one.
    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |->
            (o_result.live_count == $past(o_result.live_count)))
        else $error("live count changed on a refused command");

    // A full table returns all data fields as zero.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_FULL)) |->
            ((o_result.handle_out == '0) && (o_result.dense_out == '0) &&
             (o_result.payload_out == '0) && (o_result.energy_out == '0)))
        else $error("full result carries nonzero data");

endmodule

bind handle_packed_slot_table hpst_checker u_hpst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);
